// ===== design/blg_pkg.sv =====
`timescale 1ns / 1ps

package blg_pkg;

  localparam int unsigned BURST_DEF     = 16;
  localparam int unsigned AVG_DEPTH_DEF = 8;

  localparam int unsigned PIN_W      = 12;
  localparam int unsigned MV_W       = 13;
  localparam int unsigned CAP_W      = 10;
  localparam int unsigned BARS_W     = 3;
  localparam int unsigned RATIO_W    = 14;
  localparam int unsigned RATIO_FRAC = 10;
  localparam int unsigned SUM_W      = 16;
  localparam int unsigned PROD_W     = SUM_W + RATIO_W;

  localparam logic [RATIO_W-1:0] RATIO_RST = RATIO_W'(2048);
  localparam logic [MV_W-1:0]    MV_MAX    = MV_W'(8191);
  localparam logic [CAP_W-1:0]   CAP_MAX   = CAP_W'(1000);

  // shared divider: numerator covers the scaled burst sum, divisor covers the widest span
  localparam int unsigned DIV_NW = PROD_W - RATIO_FRAC;
  localparam int unsigned DIV_DW = 9;

  // LiPo discharge curve
  localparam int unsigned CURVE_N = 8;
  localparam int unsigned SEG_W   = 3;
  localparam int unsigned DIFF_W  = 9;
  localparam int unsigned RISE_W  = 8;

  localparam logic [MV_W-1:0] CURVE_MV [CURVE_N] = '{
    13'd3000, 13'd3270, 13'd3530, 13'd3670, 13'd3790, 13'd3870, 13'd3980, 13'd4200
  };
  localparam logic [CAP_W-1:0] CURVE_PM [CURVE_N] = '{
    10'd0, 10'd50, 10'd100, 10'd300, 10'd500, 10'd750, 10'd900, 10'd1000
  };
  localparam logic [DIV_DW-1:0] CURVE_SPAN [CURVE_N-1] = '{
    9'd270, 9'd260, 9'd140, 9'd120, 9'd80, 9'd110, 9'd220
  };
  localparam logic [RISE_W-1:0] CURVE_RISE [CURVE_N-1] = '{
    8'd50, 8'd50, 8'd200, 8'd200, 8'd250, 8'd150, 8'd100
  };

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_MV,
    ST_AVG,
    ST_DIV_AVG,
    ST_SEG,
    ST_DIV_CAP,
    ST_OUT
  } blg_state_e;

endpackage

// ===== design/blg_div.sv =====
`timescale 1ns / 1ps

module blg_div import blg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(DIV_NW + 1);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIV_NW-1:0] quot_q;
  logic [DIV_DW-1:0] rem_q;
  logic [DIV_DW-1:0] den_q;

  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW:0]   trial;
  logic              fits;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q, quot_q[DIV_NW-1]};
    trial  = rem_sh - {1'b0, den_q};
    fits   = ~trial[DIV_DW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(DIV_NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q <= req_i.num;
      rem_q  <= '0;
      den_q  <= req_i.den;
    end else if (busy_q) begin
      rem_q  <= fits ? trial[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
      quot_q <= {quot_q[DIV_NW-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider restarted while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a run");

  a_start_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> (req_i.den != '0))
    else $error("divider started with zero divisor");

endmodule

// ===== design/blg_bars.sv =====
`timescale 1ns / 1ps

module blg_bars import blg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CAP_W-1:0]  cap_i,
  input  logic              update_i,
  output logic [BARS_W-1:0] bars_o
);

  localparam logic [BARS_W-1:0] B0 = BARS_W'(0);
  localparam logic [BARS_W-1:0] B1 = BARS_W'(1);
  localparam logic [BARS_W-1:0] B2 = BARS_W'(2);
  localparam logic [BARS_W-1:0] B3 = BARS_W'(3);
  localparam logic [BARS_W-1:0] B4 = BARS_W'(4);

  logic [BARS_W-1:0] held_q;
  logic              known_q;
  logic [BARS_W-1:0] bars_d;

  always_comb begin
    bars_d = held_q;
    if (!known_q) begin
      priority if (cap_i >= CAP_W'(750)) bars_d = B4;
      else if (cap_i >= CAP_W'(500))     bars_d = B3;
      else if (cap_i >= CAP_W'(250))     bars_d = B2;
      else if (cap_i >= CAP_W'(100))     bars_d = B1;
      else                               bars_d = B0;
    end else begin
      // hysteresis: falls at most one step, rises straight to the highest threshold met; rising tests first
      priority if (held_q < B4 && cap_i >= CAP_W'(800)) bars_d = B4;
      else if (held_q < B3 && cap_i >= CAP_W'(550))     bars_d = B3;
      else if (held_q < B2 && cap_i >= CAP_W'(300))     bars_d = B2;
      else if (held_q < B1 && cap_i >= CAP_W'(150))     bars_d = B1;
      else if (held_q > B3 && cap_i < CAP_W'(700))      bars_d = B3;
      else if (held_q > B2 && cap_i < CAP_W'(450))      bars_d = B2;
      else if (held_q > B1 && cap_i < CAP_W'(200))      bars_d = B1;
      else if (held_q > B0 && cap_i < CAP_W'(50))       bars_d = B0;
      else                                              bars_d = held_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= B0;
      known_q <= 1'b0;
    end else if (update_i) begin
      held_q  <= bars_d;
      known_q <= 1'b1;
    end
  end

  assign bars_o = bars_d;

  a_bars_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= B4)
    else $error("bar count out of range");

  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (update_i && known_q && held_q < B4 && held_q > B0) |=>
      (held_q >= $past(held_q) - B1))
    else $error("hysteresis dropped more than one step");

endmodule

// ===== design/battery_level_gauge.sv =====
`timescale 1ns / 1ps

// channel | dir | handshake                 | word
// --------+-----+---------------------------+----------------------------------------------
// in      | in  | in_valid_i / in_ready_o   | pin_millivolts_i
// out     | out | out_valid_o / out_ready_i | battery_millivolts_o, capacity_permille_o,
//         |     |                           | level_bars_o
// cfg     | in  | cfg_we_i (no wait)        | cfg_wdata_i (divider_ratio_q10)
//
// Input words are taken only while the block is idle. After the word closing a burst, in_ready_o
// stays low through up to three passes through the shared bit-serial divider (scaling,
// averaging, interpolation) and until the result is loaded into the output register.
// Reset clears the control state; the ring memory is not cleared, only written entries are read.
// A stalled output word holds in the output register; the block waits for it to drain.

module battery_level_gauge import blg_pkg::*; #(
  parameter int unsigned BURST     = BURST_DEF,
  parameter int unsigned AVG_DEPTH = AVG_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [PIN_W-1:0]   pin_millivolts_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [MV_W-1:0]    battery_millivolts_o,
  output logic [CAP_W-1:0]   capacity_permille_o,
  output logic [BARS_W-1:0]  level_bars_o,
  input  logic               cfg_we_i,
  input  logic [RATIO_W-1:0] cfg_wdata_i
);

  localparam int unsigned BC_W  = (BURST > 1) ? $clog2(BURST) : 1;
  localparam int unsigned POS_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(AVG_DEPTH + 1);
  localparam int unsigned TOT_W = MV_W + $clog2(AVG_DEPTH);
  localparam int unsigned IP_W  = DIFF_W + RISE_W;

  blg_state_e state_q, state_d;

  logic [RATIO_W-1:0] ratio_q;
  logic [SUM_W-1:0]   sum_q;
  logic [BC_W-1:0]    burst_cnt_q;
  logic [POS_W-1:0]   pos_q;
  logic               ring_full_q;
  logic [TOT_W-1:0]   total_q;
  logic [CNT_W-1:0]   ring_cnt_q;
  logic [MV_W-1:0]    ring_rd_q;
  logic [MV_W-1:0]    avg_q;
  logic [SEG_W-1:0]   seg_q;
  logic [CAP_W-1:0]   cap_q;
  logic               out_valid_q;
  logic [MV_W-1:0]    out_mv_q;
  logic [CAP_W-1:0]   out_cap_q;
  logic [BARS_W-1:0]  out_bars_q;

  logic [MV_W-1:0]    ring_mem [AVG_DEPTH];

  logic               accept;
  logic               burst_end;
  logic [PROD_W-1:0]  scaled_prod;
  logic [MV_W-1:0]    mv_sat;
  logic [SEG_W-1:0]   seg_sel;
  logic               seg_below;
  logic               seg_above;
  logic [MV_W-1:0]    seg_diff;
  logic [IP_W-1:0]    interp_prod;
  logic [BARS_W-1:0]  bars_next;
  logic               ld_mv;
  logic               ld_avg;
  logic               ld_seg;
  logic               ld_cap;
  logic               ld_out;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign burst_end  = (burst_cnt_q == BC_W'(BURST - 1));

  assign scaled_prod = PROD_W'(sum_q) * PROD_W'(ratio_q);
  assign mv_sat = (div_rsp.quot > DIV_NW'(MV_MAX)) ? MV_MAX : div_rsp.quot[MV_W-1:0];

  always_comb begin
    seg_sel = '0;
    for (int i = int'(CURVE_N) - 2; i >= 0; i--) begin
      if (avg_q < CURVE_MV[i+1]) seg_sel = SEG_W'(i);
    end
  end

  assign seg_below   = (avg_q <= CURVE_MV[0]);
  assign seg_above   = (avg_q >= CURVE_MV[CURVE_N-1]);
  assign seg_diff    = avg_q - CURVE_MV[seg_sel];
  assign interp_prod = IP_W'(seg_diff[DIFF_W-1:0]) * IP_W'(CURVE_RISE[seg_sel]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    div_req = '0;
    ld_mv   = 1'b0;
    ld_avg  = 1'b0;
    ld_seg  = 1'b0;
    ld_cap  = 1'b0;
    ld_out  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && burst_end) state_d = ST_MUL;
      end
      ST_MUL: begin
        div_req.start = 1'b1;
        div_req.num   = scaled_prod[PROD_W-1:RATIO_FRAC];
        div_req.den   = DIV_DW'(BURST);
        state_d       = ST_DIV_MV;
      end
      ST_DIV_MV: begin
        if (div_rsp.done) begin
          ld_mv   = 1'b1;
          state_d = ST_AVG;
        end
      end
      ST_AVG: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NW'(total_q);
        div_req.den   = DIV_DW'(ring_cnt_q);
        state_d       = ST_DIV_AVG;
      end
      ST_DIV_AVG: begin
        if (div_rsp.done) begin
          ld_avg  = 1'b1;
          state_d = ST_SEG;
        end
      end
      ST_SEG: begin
        ld_seg = 1'b1;
        if (seg_below || seg_above) begin
          state_d = ST_OUT;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = DIV_NW'(interp_prod);
          div_req.den   = CURVE_SPAN[seg_sel];
          state_d       = ST_DIV_CAP;
        end
      end
      ST_DIV_CAP: begin
        if (div_rsp.done) begin
          ld_cap  = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          ld_out  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q     <= RATIO_RST;
      sum_q       <= '0;
      burst_cnt_q <= '0;
      pos_q       <= '0;
      ring_full_q <= 1'b0;
      total_q     <= '0;
      ring_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) ratio_q <= cfg_wdata_i;
      if (accept) begin
        sum_q       <= sum_q + SUM_W'(pin_millivolts_i);
        burst_cnt_q <= burst_end ? '0 : burst_cnt_q + BC_W'(1);
      end else if (state_q == ST_MUL) begin
        sum_q <= '0;
      end
      if (ld_mv) begin
        total_q <= total_q - (ring_full_q ? TOT_W'(ring_rd_q) : '0) + TOT_W'(mv_sat);
        if (ring_full_q || pos_q == POS_W'(AVG_DEPTH - 1)) begin
          ring_cnt_q <= CNT_W'(AVG_DEPTH);
        end else begin
          ring_cnt_q <= CNT_W'(pos_q) + CNT_W'(1);
        end
        if (pos_q == POS_W'(AVG_DEPTH - 1)) begin
          pos_q       <= '0;
          ring_full_q <= 1'b1;
        end else begin
          pos_q <= pos_q + POS_W'(1);
        end
      end
      if (ld_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ring_rd_q <= ring_mem[pos_q];
    if (ld_mv) ring_mem[pos_q] <= mv_sat;
  end

  always_ff @(posedge clk_i) begin
    if (ld_avg) avg_q <= div_rsp.quot[MV_W-1:0];
    if (ld_seg) begin
      seg_q <= seg_sel;
      cap_q <= seg_above ? CAP_MAX : '0;
    end
    if (ld_cap) cap_q <= CURVE_PM[seg_q] + div_rsp.quot[CAP_W-1:0];
    if (ld_out) begin
      out_mv_q   <= avg_q;
      out_cap_q  <= cap_q;
      out_bars_q <= bars_next;
    end
  end

  blg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  blg_bars u_bars (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cap_i    (cap_q),
    .update_i (ld_out),
    .bars_o   (bars_next)
  );

  assign out_valid_o          = out_valid_q;
  assign battery_millivolts_o = out_mv_q;
  assign capacity_permille_o  = out_cap_q;
  assign level_bars_o         = out_bars_q;

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |->
      (state_q == ST_DIV_MV || state_q == ST_DIV_AVG || state_q == ST_DIV_CAP))
    else $error("divider result arrived with no pending request");

  a_ring_full_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_full_q |=> ring_full_q)
    else $error("ring full flag dropped");

  a_burst_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && burst_end) |=> (state_q == ST_MUL && burst_cnt_q == '0))
    else $error("burst close did not start scaling");

  a_cap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> (cap_q <= CAP_MAX))
    else $error("capacity above full scale");

endmodule
